[rtl/touch_event_packet_parser_assert.svh]
// Assertion helpers for the checker of the touch packet parser.
// Both expect clk_i and rst_ni in the scope where they are used.
`ifndef TOUCH_EVENT_PACKET_PARSER_ASSERT_SVH
`define TOUCH_EVENT_PACKET_PARSER_ASSERT_SVH

// Property that must hold at every clock edge outside reset.
`define TEPP_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Condition that must never be seen outside reset.
`define TEPP_ASSERT_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) else $error(msg);

`endif

[rtl/tepp_pkg.sv]
`default_nettype none

package tepp_pkg;

  localparam int unsigned ByteW   = 8;
  localparam int unsigned CoordW  = 16;
  localparam int unsigned StatusW = 2;
  localparam int unsigned CfgIdxW = 2;

  localparam logic [ByteW-1:0] TouchLen  = 8'd5;
  localparam logic [ByteW-1:0] RemXLow   = 8'd4;
  localparam logic [ByteW-1:0] RemXHigh  = 8'd3;
  localparam logic [ByteW-1:0] RemYLow   = 8'd2;
  localparam logic [ByteW-1:0] RemYHigh  = 8'd1;

  localparam logic [ByteW-1:0] EscapeReset    = 8'd27;
  localparam logic [ByteW-1:0] TouchIdReset   = 8'd72;
  localparam logic [ByteW-1:0] TouchDownReset = 8'd1;

  typedef enum logic [2:0] {
    PhWaitEsc  = 3'd0,
    PhId       = 3'd1,
    PhLenTouch = 3'd2,
    PhLenSkip  = 3'd3,
    PhSkip     = 3'd4,
    PhType     = 3'd5,
    PhData     = 3'd6,
    PhHunt     = 3'd7
  } phase_e;

  typedef enum logic [StatusW-1:0] {
    StatusOk     = 2'd0,
    StatusNoEsc  = 2'd1,
    StatusBadLen = 2'd2
  } status_e;

  typedef enum logic [CfgIdxW-1:0] {
    CfgEscape    = 2'd0,
    CfgTouchId   = 2'd1,
    CfgTouchDown = 2'd2
  } cfg_idx_e;

  typedef struct packed {
    logic [StatusW-1:0] status;
    logic [ByteW-1:0]   event_kind;
    logic [CoordW-1:0]  pos_x;
    logic [CoordW-1:0]  pos_y;
    logic               deliver;
  } result_t;

endpackage

`default_nettype wire

[rtl/tepp_intf.sv]
`default_nettype none

interface tepp_byte_if;
  logic                         valid;
  logic                         ready;
  logic [tepp_pkg::ByteW-1:0]   data_byte;

  modport source (output valid, output data_byte, input ready);
  modport sink (input valid, input data_byte, output ready);
endinterface

interface tepp_event_if;
  logic                         valid;
  logic                         ready;
  logic [tepp_pkg::StatusW-1:0] status;
  logic [tepp_pkg::ByteW-1:0]   event_kind;
  logic [tepp_pkg::CoordW-1:0]  pos_x;
  logic [tepp_pkg::CoordW-1:0]  pos_y;
  logic                         deliver;

  modport source (
    output valid, output status, output event_kind, output pos_x, output pos_y,
    output deliver, input ready
  );
  modport sink (
    input valid, input status, input event_kind, input pos_x, input pos_y,
    input deliver, output ready
  );
endinterface

`default_nettype wire

[rtl/touch_event_packet_parser.sv]
// The byte that ends a result is registered, then the result is buffered.
// Throughput: 1 byte per cycle while the buffer has room (single-pass state update).
// A 2-entry result buffer keeps bytes flowing while a result waits to be taken.
// Reset (rst_ni low, asynchronous): parser waits for an escape byte, buffers empty,
// escape/touch-id/touch-down codes return to 27, 72 and 1.
`default_nettype none

module touch_event_packet_parser (
  input  wire                           clk_i,
  input  wire                           rst_ni,
  tepp_byte_if.sink                     byte_i,
  tepp_event_if.source                  event_o,
  input  wire                           cfg_we_i,
  input  wire  [tepp_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  wire  [tepp_pkg::ByteW-1:0]    cfg_data_i
);

  logic                       in_valid;
  logic [tepp_pkg::ByteW-1:0] in_data;
  logic                       fifo_full;
  logic                       take;
  logic                       res_valid;
  tepp_pkg::result_t          res;

  // Advance the held byte whenever the result buffer has room.
  assign take = in_valid && !fifo_full;

  tepp_in_stage u_in (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .byte_i  (byte_i),
    .take_i  (take),
    .valid_o (in_valid),
    .data_o  (in_data)
  );

  tepp_parser u_parser (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i),
    .take_i      (take),
    .data_byte_i (in_data),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  tepp_out_fifo u_out (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (take && res_valid),
    .data_i  (res),
    .full_o  (fifo_full),
    .event_o (event_o)
  );

endmodule

`default_nettype wire

[rtl/tepp_in_stage.sv]
`default_nettype none

module tepp_in_stage (
  input  wire                          clk_i,
  input  wire                          rst_ni,
  tepp_byte_if.sink                    byte_i,
  input  wire                          take_i,
  output logic                         valid_o,
  output logic [tepp_pkg::ByteW-1:0]   data_o
);

  logic                       valid_q, valid_d;
  logic [tepp_pkg::ByteW-1:0] data_q, data_d;
  logic                       load;

  // Refill in the same cycle the held byte moves on.
  assign byte_i.ready = !valid_q || take_i;
  assign load         = byte_i.valid && byte_i.ready;

  always_comb begin
    valid_d = valid_q;
    data_d  = data_q;
    if (load) begin
      valid_d = 1'b1;
      data_d  = byte_i.data_byte;
    end else if (take_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

`default_nettype wire

[rtl/tepp_parser.sv]
`default_nettype none

module tepp_parser (
  input  wire                            clk_i,
  input  wire                            rst_ni,
  input  wire                            cfg_we_i,
  input  wire  [tepp_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  wire  [tepp_pkg::ByteW-1:0]     cfg_data_i,
  input  wire                            take_i,
  input  wire  [tepp_pkg::ByteW-1:0]     data_byte_i,
  output logic                           res_valid_o,
  output tepp_pkg::result_t              res_o
);

  logic [tepp_pkg::ByteW-1:0]  esc_q, tid_q, tdown_q;
  tepp_pkg::phase_e            phase_q, phase_d;
  logic [tepp_pkg::ByteW-1:0]  rem_q, rem_d, rem_dec;
  logic [tepp_pkg::ByteW-1:0]  type_q, type_d;
  logic [tepp_pkg::CoordW-1:0] x_q, x_d;
  logic [tepp_pkg::ByteW-1:0]  ylo_q, ylo_d;
  logic [tepp_pkg::ByteW-1:0]  b;

  assign b       = data_byte_i;
  assign rem_dec = (rem_q == '0) ? '0 : rem_q - 8'd1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      esc_q   <= tepp_pkg::EscapeReset;
      tid_q   <= tepp_pkg::TouchIdReset;
      tdown_q <= tepp_pkg::TouchDownReset;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        tepp_pkg::CfgEscape:    esc_q   <= cfg_data_i;
        tepp_pkg::CfgTouchId:   tid_q   <= cfg_data_i;
        tepp_pkg::CfgTouchDown: tdown_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_comb begin
    phase_d     = phase_q;
    rem_d       = rem_q;
    type_d      = type_q;
    x_d         = x_q;
    ylo_d       = ylo_q;
    res_valid_o = 1'b0;
    res_o       = '0;
    case (phase_q)
      tepp_pkg::PhWaitEsc: begin
        if (b == esc_q) begin
          phase_d = tepp_pkg::PhId;
        end else begin
          phase_d      = tepp_pkg::PhHunt;
          res_valid_o  = 1'b1;
          res_o.status = tepp_pkg::StatusNoEsc;
        end
      end
      tepp_pkg::PhHunt: begin
        if (b == esc_q) phase_d = tepp_pkg::PhId;
      end
      tepp_pkg::PhId: begin
        phase_d = (b == tid_q) ? tepp_pkg::PhLenTouch : tepp_pkg::PhLenSkip;
      end
      tepp_pkg::PhLenTouch: begin
        if (b == tepp_pkg::TouchLen) begin
          phase_d = tepp_pkg::PhType;
        end else begin
          rem_d        = b;
          phase_d      = (b == '0) ? tepp_pkg::PhWaitEsc : tepp_pkg::PhSkip;
          res_valid_o  = 1'b1;
          res_o.status = tepp_pkg::StatusBadLen;
        end
      end
      tepp_pkg::PhLenSkip: begin
        rem_d   = b;
        phase_d = (b == '0) ? tepp_pkg::PhWaitEsc : tepp_pkg::PhSkip;
      end
      tepp_pkg::PhSkip: begin
        rem_d = rem_dec;
        if (rem_dec == '0) phase_d = tepp_pkg::PhWaitEsc;
      end
      tepp_pkg::PhType: begin
        type_d  = b;
        rem_d   = tepp_pkg::RemXLow;
        phase_d = tepp_pkg::PhData;
      end
      tepp_pkg::PhData: begin
        if (rem_q == tepp_pkg::RemXLow) begin
          x_d   = {8'h00, b};
          rem_d = tepp_pkg::RemXHigh;
        end else if (rem_q == tepp_pkg::RemXHigh) begin
          x_d   = x_q | {b, 8'h00};
          rem_d = tepp_pkg::RemYLow;
        end else if (rem_q == tepp_pkg::RemYLow) begin
          ylo_d = b;
          rem_d = tepp_pkg::RemYHigh;
        end else begin
          rem_d            = '0;
          phase_d          = tepp_pkg::PhWaitEsc;
          res_valid_o      = 1'b1;
          res_o.status     = tepp_pkg::StatusOk;
          res_o.event_kind = type_q;
          res_o.pos_x      = x_q;
          res_o.pos_y      = {b, ylo_q};
          res_o.deliver    = (type_q != tdown_q);
        end
      end
      default: phase_d = tepp_pkg::PhWaitEsc;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= tepp_pkg::PhWaitEsc;
      rem_q   <= '0;
      type_q  <= '0;
      x_q     <= '0;
      ylo_q   <= '0;
    end else if (take_i) begin
      phase_q <= phase_d;
      rem_q   <= rem_d;
      type_q  <= type_d;
      x_q     <= x_d;
      ylo_q   <= ylo_d;
    end
  end

endmodule

`default_nettype wire

[rtl/tepp_out_fifo.sv]
`default_nettype none

module tepp_out_fifo (
  input  wire                clk_i,
  input  wire                rst_ni,
  input  wire                push_i,
  input  tepp_pkg::result_t  data_i,
  output logic               full_o,
  tepp_event_if.source       event_o
);

  logic [1:0]        count_q, count_d;
  tepp_pkg::result_t slot0_q, slot0_d, slot1_q, slot1_d;
  logic              pop;

  assign pop    = event_o.valid && event_o.ready;
  assign full_o = count_q[1];

  always_comb begin
    count_d = count_q;
    slot0_d = slot0_q;
    slot1_d = slot1_q;
    if (pop && !push_i) begin
      slot0_d = slot1_q;
      count_d = count_q - 2'd1;
    end else if (push_i && !pop) begin
      if (count_q == 2'd0) slot0_d = data_i;
      else                 slot1_d = data_i;
      count_d = count_q + 2'd1;
    end else if (push_i && pop) begin
      // Head leaves while a new result arrives: count holds.
      if (count_q == 2'd1) begin
        slot0_d = data_i;
      end else begin
        slot0_d = slot1_q;
        slot1_d = data_i;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= 2'd0;
    end else begin
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    slot0_q <= slot0_d;
    slot1_q <= slot1_d;
  end

  assign event_o.valid      = (count_q != 2'd0);
  assign event_o.status     = slot0_q.status;
  assign event_o.event_kind = slot0_q.event_kind;
  assign event_o.pos_x      = slot0_q.pos_x;
  assign event_o.pos_y      = slot0_q.pos_y;
  assign event_o.deliver    = slot0_q.deliver;

endmodule

`default_nettype wire

[rtl/tepp_checker.sv]
`default_nettype none
`include "touch_event_packet_parser_assert.svh"

module tepp_checker (
  input wire                           clk_i,
  input wire                           rst_ni,
  input wire                           in_valid,
  input wire                           in_ready,
  input wire                           out_valid,
  input wire                           out_ready,
  input wire [tepp_pkg::StatusW-1:0]   status,
  input wire [tepp_pkg::ByteW-1:0]     event_kind,
  input wire [tepp_pkg::CoordW-1:0]    pos_x,
  input wire [tepp_pkg::CoordW-1:0]    pos_y,
  input wire                           deliver
);

  `TEPP_ASSERT(a_stall_hold, out_valid && !out_ready |=> out_valid && $stable(status) && $stable(event_kind) && $stable(pos_x) && $stable(pos_y) && $stable(deliver), "result changed while stalled")
  `TEPP_ASSERT(a_status_code, out_valid |-> status == tepp_pkg::StatusOk || status == tepp_pkg::StatusNoEsc || status == tepp_pkg::StatusBadLen, "undefined status code")
  `TEPP_ASSERT(a_error_zero, out_valid && status != tepp_pkg::StatusOk |-> event_kind == '0 && pos_x == '0 && pos_y == '0 && !deliver, "error result carries nonzero fields")
  `TEPP_ASSERT(a_result_cause, $rose(out_valid) |-> $past(in_valid && in_ready, 2), "result without a recent byte transfer")

endmodule

bind touch_event_packet_parser tepp_checker u_tepp_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .in_valid   (byte_i.valid),
  .in_ready   (byte_i.ready),
  .out_valid  (event_o.valid),
  .out_ready  (event_o.ready),
  .status     (event_o.status),
  .event_kind (event_o.event_kind),
  .pos_x      (event_o.pos_x),
  .pos_y      (event_o.pos_y),
  .deliver    (event_o.deliver)
);

`default_nettype wire
